@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the packet FIFO RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFOP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packet fifo assertion failed");

// Next-cycle implication, disabled during reset.
`define PFOP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packet fifo assertion failed");

`endif

@@ rtl/core/pfop_pkg.sv @@
// Package for the packet FIFO with overflow policy.
// Holds sizes, codes, state encoding and port structs; depends on nothing.
package pfop_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 64;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CAP_W      = 11;
  localparam int PCT_W      = 7;
  localparam int NUM_W      = PTR_W + PCT_W;
  localparam int CNT_W      = 32;
  localparam int ITER_W     = $clog2(NUM_W + 1);
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_POLICY   = 1'b1;

  localparam logic [CAP_W-1:0] CAP_MIN = CAP_W'(2);
  localparam logic [CAP_W-1:0] CAP_MAX = CAP_W'(DEPTH);
  localparam logic [PCT_W-1:0] PERCENT = PCT_W'(100);

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_PEEK  = 2'd2,
    KIND_FLUSH = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    POL_DROP_OLDEST  = 2'd0,
    POL_DROP_NEWEST  = 2'd1,
    POL_BLOCK_WRITER = 2'd2
  } policy_t;

  typedef enum logic [1:0] {
    STAT_DONE     = 2'd0,
    STAT_DROPPED  = 2'd1,
    STAT_REPLACED = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] data_in;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [9:0]  fill_count;
    logic [6:0]  fill_percent;
    logic        full_flag;
    logic        overflow_seen;
    logic        underflow_seen;
    logic [31:0] overrun_count;
    logic [31:0] underrun_count;
    logic [31:0] written_count;
    logic [31:0] taken_count;
  } result_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [CAP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [PCT_W-1:0] quot;
  } div_resp_t;

endpackage

@@ rtl/core/pfop_div.sv @@
// Serial restoring divider for the fill percentage, one quotient bit per cycle.
// Depends on pfop_pkg.
module pfop_div (
  input  logic               clk,
  input  logic               rst,
  input  pfop_pkg::div_req_t  div_req,
  output pfop_pkg::div_resp_t div_resp
);
  import pfop_pkg::*;

  logic [CAP_W-1:0]  rem;
  logic [CAP_W-1:0]  den;
  logic [NUM_W-1:0]  num_sh;
  logic [NUM_W-1:0]  quot;
  logic [ITER_W-1:0] iter;
  logic              active;
  logic              done;
  logic [CAP_W:0]    trial;
  logic              fits;

  assign trial = {rem, num_sh[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      iter   <= '0;
    end else begin
      done <= 1'b0;
      if (div_req.start) begin
        active <= 1'b1;
        iter   <= ITER_W'(NUM_W);
      end else if (active) begin
        iter <= iter - ITER_W'(1);
        if (iter == ITER_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_req.start) begin
      rem    <= '0;
      den    <= div_req.den;
      num_sh <= div_req.num;
      quot   <= '0;
    end else if (active) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      quot   <= {quot[NUM_W-2:0], fits};
      if (fits) begin
        rem <= CAP_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[CAP_W-1:0];
      end
    end
  end

  assign div_resp.done = done;
  assign div_resp.quot = quot[PCT_W-1:0];

endmodule

@@ rtl/core/packet_fifo_overflow_policy.sv @@
// Top level of the packet FIFO with overflow policy: sequencer, ring store, counters.
// Depends on pfop_pkg, pfop_div and assert_macros.svh.
//
// A request is taken when start is high and busy is low; its result is shown for exactly
// one cycle with done high, and busy falls in the cycle after that, so a new request is
// taken only after the last one is through. A request passes in order through the ring
// memory access, the launch of the divide, the 17-step serial divider that forms the fill
// percentage, the divider's finishing flag and the presentation of the result. The
// receiver cannot hold off a result. Configuration writes are taken only while busy is
// low, and a capacity write empties the ring.
`include "assert_macros.svh"

module packet_fifo_overflow_policy (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pfop_pkg::request_t             request,
  output logic                           done,
  output pfop_pkg::result_t              result,
  input  logic                           cfg_we,
  input  logic [pfop_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pfop_pkg::CAP_W-1:0]     cfg_data
);
  import pfop_pkg::*;

  state_t state, state_next;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] data_word;

  logic [CAP_W-1:0] capacity;
  logic [1:0]       policy;
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [1:0]       kind;
  logic [63:0]      data_in;
  logic [1:0]       status;
  logic [PTR_W-1:0] fill_count;
  logic [CNT_W-1:0] overruns;
  logic [CNT_W-1:0] underruns;
  logic [CNT_W-1:0] stored;
  logic [CNT_W-1:0] taken;
  logic             overflow_sticky;
  logic             underflow_state;

  logic [CAP_W-1:0] cap_eff;
  logic [CAP_W-1:0] head_inc;
  logic [CAP_W-1:0] tail_inc;
  logic [PTR_W-1:0] head_adv;
  logic [PTR_W-1:0] tail_adv;
  logic [CAP_W-1:0] held;
  logic             empty;
  logic             full;
  logic             accept;
  logic             wr_en;

  div_req_t  div_req;
  div_resp_t div_resp;

  assign accept = start && !busy;

  always_comb begin
    if (capacity < CAP_MIN) begin
      cap_eff = CAP_MIN;
    end else if (capacity > CAP_MAX) begin
      cap_eff = CAP_MAX;
    end else begin
      cap_eff = capacity;
    end
  end

  assign head_inc = {1'b0, head} + CAP_W'(1);
  assign tail_inc = {1'b0, tail} + CAP_W'(1);
  assign head_adv = (head_inc >= cap_eff) ? '0 : head_inc[PTR_W-1:0];
  assign tail_adv = (tail_inc >= cap_eff) ? '0 : tail_inc[PTR_W-1:0];
  assign empty    = head == tail;
  assign full     = head_adv == tail;
  assign held     = (head >= tail) ? CAP_W'({1'b0, head} - {1'b0, tail})
                                   : CAP_W'(cap_eff - {1'b0, tail} + {1'b0, head});

  // A write stores unless the ring is full and the policy keeps the oldest entries.
  assign wr_en = (state == ST_EXEC) && (kind == KIND_WRITE) &&
                 (!full || policy == POL_DROP_OLDEST);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head] <= data_in[DATA_WIDTH-1:0];
    end
    if (accept) begin
      rd_word <= mem[tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: state_next = ST_DIV;
      ST_DIV:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (div_resp.done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy          = state != ST_IDLE;
    done          = state == ST_DONE;
    div_req.start = state == ST_DIV;
    div_req.num   = NUM_W'(held[PTR_W-1:0]) * NUM_W'(PERCENT);
    div_req.den   = cap_eff;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind    <= request.kind;
      data_in <= request.data_in;
    end
    if (state == ST_DIV) begin
      fill_count <= held[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity        <= CAP_MAX;
      policy          <= POL_DROP_OLDEST;
      head            <= '0;
      tail            <= '0;
      overruns        <= '0;
      underruns       <= '0;
      stored          <= '0;
      taken           <= '0;
      overflow_sticky <= 1'b0;
      underflow_state <= 1'b0;
      status          <= STAT_DONE;
      data_word       <= '0;
    end else if (state == ST_IDLE) begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: begin
            capacity <= cfg_data;
            head     <= '0;
            tail     <= '0;
          end
          REG_POLICY: policy <= cfg_data[1:0];
          default: ;
        endcase
      end
    end else if (state == ST_EXEC) begin
      status    <= STAT_DONE;
      data_word <= '0;
      case (kind)
        KIND_WRITE: begin
          if (full) begin
            overruns <= overruns + CNT_W'(1);
            if (policy == POL_DROP_OLDEST) begin
              tail            <= tail_adv;
              overflow_sticky <= 1'b1;
              status          <= STAT_REPLACED;
            end else begin
              status <= STAT_DROPPED;
            end
          end
          if (wr_en) begin
            head   <= head_adv;
            stored <= stored + CNT_W'(1);
          end
        end
        KIND_READ: begin
          if (empty) begin
            underruns       <= underruns + CNT_W'(1);
            underflow_state <= 1'b1;
            status          <= STAT_DROPPED;
          end else begin
            data_word       <= rd_word;
            tail            <= tail_adv;
            taken           <= taken + CNT_W'(1);
            underflow_state <= 1'b0;
          end
        end
        KIND_PEEK: begin
          if (empty) begin
            status <= STAT_DROPPED;
          end else begin
            data_word <= rd_word;
          end
        end
        KIND_FLUSH: tail <= head;
        default: ;
      endcase
    end
  end

  always_comb begin
    result.status         = status;
    result.data_out       = 64'(data_word);
    result.fill_count     = fill_count;
    result.fill_percent   = div_resp.quot;
    result.full_flag      = full;
    result.overflow_seen  = overflow_sticky;
    result.underflow_seen = underflow_state;
    result.overrun_count  = overruns;
    result.underrun_count = underruns;
    result.written_count  = stored;
    result.taken_count    = taken;
  end

  pfop_div u_div (
    .clk      (clk),
    .rst      (rst),
    .div_req  (div_req),
    .div_resp (div_resp)
  );

  `PFOP_ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  `PFOP_ASSERT_NEXT(a_accept_busy, clk, rst, accept, busy && !done)
  `PFOP_ASSERT_NOW(a_fill_below_cap, clk, rst, done, {1'b0, result.fill_count} < cap_eff)
  `PFOP_ASSERT_NOW(a_percent_range, clk, rst, done, result.fill_percent < PERCENT)

endmodule
